/* design/cau_pkg.sv */
`default_nettype none

package cau_pkg;

    localparam int FIELD_W = 32;
    localparam int KIND_W  = 3;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int NUM_W   = PROD_W + FRAC_W;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4
    } op_t;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        data_t             re;
        data_t             im;
        logic              ovf;
        logic              dz;
        logic              neg_re;
        logic              neg_im;
    } side_t;

endpackage

`default_nettype wire

/* design/cau_op_if.sv */
`default_nettype none

interface cau_op_if;
    import cau_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] a_re;
    logic signed [FIELD_W-1:0] a_im;
    logic signed [FIELD_W-1:0] b_re;
    logic signed [FIELD_W-1:0] b_im;

    modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, kind, a_re, a_im, b_re, b_im, output ready);

endinterface

`default_nettype wire

/* design/cau_res_if.sv */
`default_nettype none

interface cau_res_if;
    import cau_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] res_re;
    logic signed [FIELD_W-1:0] res_im;
    logic                      div_by_zero;
    logic                      overflow;

    modport source (output valid, res_re, res_im, div_by_zero, overflow, input ready);
    modport sink (input valid, res_re, res_im, div_by_zero, overflow, output ready);

endinterface

`default_nettype wire

/* design/cau_div.sv */
`default_nettype none

module cau_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [cau_pkg::PROD_W-1:0]   mag,
    input  logic [cau_pkg::PROD_W-1:0]   den,
    output logic [cau_pkg::DATA_W-1:0]   quo,
    output logic                         big
);
    import cau_pkg::*;

    localparam int STAGES = DATA_W;

    logic [PROD_W-1:0] rem_reg [0:STAGES];
    logic [PROD_W-1:0] den_reg [0:STAGES];
    logic [DATA_W-1:0] x_reg   [0:STAGES];
    logic [DATA_W-1:0] q_reg   [0:STAGES];
    logic              big_reg [0:STAGES];

    logic [PROD_W-1:0] rem_next [0:STAGES];
    logic [DATA_W-1:0] x_next   [0:STAGES];
    logic [DATA_W-1:0] q_next   [0:STAGES];
    logic              big_next;
    logic [PROD_W-1:0] trial    [1:STAGES];
    logic              ge       [1:STAGES];
    logic [NUM_W-1:0]  num_x;
    logic [NUM_W-1:0]  num_hi;

    always_comb
    begin
        num_x       = NUM_W'(mag) << FRAC_W;
        num_hi      = num_x >> DATA_W;
        big_next    = num_hi >= NUM_W'(den);
        rem_next[0] = num_hi[PROD_W-1:0];
        x_next[0]   = num_x[DATA_W-1:0];
        q_next[0]   = '0;
        for (int k = 1; k <= STAGES; k++)
        begin
            trial[k]    = {rem_reg[k-1][PROD_W-2:0], x_reg[k-1][DATA_W-1]};
            ge[k]       = trial[k] >= den_reg[k-1];
            rem_next[k] = ge[k] ? (trial[k] - den_reg[k-1]) : trial[k];
            x_next[k]   = x_reg[k-1] << 1;
            q_next[k]   = {q_reg[k-1][DATA_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            big_reg[0] <= big_next;
            for (int k = 0; k <= STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                x_reg[k]   <= x_next[k];
                q_reg[k]   <= q_next[k];
            end
            for (int k = 1; k <= STAGES; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign quo = q_reg[STAGES];
    assign big = big_reg[STAGES];

endmodule

`default_nettype wire

/* design/complex_arith_unit.sv */
// Complex arithmetic unit on signed Q16.16 operands.
// The operands channel carries an operation code and the two operands a and b;
// the result channel returns one transaction per operand transaction with the
// saturated real and imaginary parts, a division-by-zero flag and an overflow flag.
// Both channels complete a transaction on a clock edge with valid and ready high.
// Every operation runs through the same pipeline, so results leave in order.
// From acceptance to valid result a transaction passes these stages in order:
// one input stage, one multiply stage for the six products, one summing stage,
// one sign and magnitude stage, DATA_W + 1 stages of the restoring divider
// (one quotient bit per stage plus the saturation check) and the output register.
// Throughput is one transaction per cycle unless stalled; the divider sets the latency.
// When the receiver stalls with a result held in the output register, the whole
// pipeline freezes and operands ready drops; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline comes up empty.
`default_nettype none

module complex_arith_unit (
    input  logic         clk,
    input  logic         rst_n,
    cau_op_if.sink       operands,
    cau_res_if.source    result
);
    import cau_pkg::*;

    localparam int DIV_LAT  = DATA_W + 1;
    localparam int SUM_W    = PROD_W + 1;
    localparam int MSH_W    = SUM_W - FRAC_W;
    localparam data_t D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t D_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic en;

    logic                     v1_reg;
    logic [KIND_W-1:0]        kind1_reg;
    data_t                    ar1_reg, ai1_reg, br1_reg, bi1_reg;

    logic                     v2_reg;
    logic [KIND_W-1:0]        kind2_reg;
    logic signed [PROD_W-1:0] prr2_reg, pii2_reg, pri2_reg, pir2_reg, pbr2_reg, pbi2_reg;
    logic signed [DATA_W:0]   sre2_reg, sim2_reg;
    logic signed [DATA_W:0]   sre_next, sim_next;

    logic                     v3_reg;
    logic [KIND_W-1:0]        kind3_reg;
    logic signed [SUM_W-1:0]  nre3_reg, nim3_reg;
    logic [PROD_W-1:0]        den3_reg;
    data_t                    cre3_reg, cim3_reg;
    logic                     covf3_reg;
    logic signed [SUM_W-1:0]  nre_next, nim_next;
    data_t                    cre_next, cim_next;
    logic                     ore, oim;

    logic                     v4_reg;
    side_t                    sb4_reg;
    logic [PROD_W-1:0]        magre4_reg, magim4_reg, den4_reg;
    side_t                    sb_next;
    logic signed [MSH_W-1:0]  fre, fim;
    logic                     mre_ovf, mim_ovf;
    data_t                    mre, mim;

    logic                     vd_reg   [0:DIV_LAT-1];
    side_t                    side_reg [0:DIV_LAT-1];

    logic [DATA_W-1:0]        qre, qim;
    logic                     bigre, bigim;

    logic                     out_valid_reg;
    data_t                    re_reg, im_reg, re_next, im_next;
    logic                     dz_reg, ovf_reg, dz_next, ovf_next;
    side_t                    sd;
    logic                     sat_re, sat_im;

    assign en             = !out_valid_reg || result.ready;
    assign operands.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg        <= operands.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            vd_reg[0]     <= v4_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
            out_valid_reg <= vd_reg[DIV_LAT-1];
        end
    end

    always_comb
    begin
        unique case (kind1_reg)
            OP_ADD:
            begin
                sre_next = (DATA_W+1)'(ar1_reg) + (DATA_W+1)'(br1_reg);
                sim_next = (DATA_W+1)'(ai1_reg) + (DATA_W+1)'(bi1_reg);
            end
            OP_SUB:
            begin
                sre_next = (DATA_W+1)'(ar1_reg) - (DATA_W+1)'(br1_reg);
                sim_next = (DATA_W+1)'(ai1_reg) - (DATA_W+1)'(bi1_reg);
            end
            OP_CONJ:
            begin
                sre_next = (DATA_W+1)'(ar1_reg);
                sim_next = -(DATA_W+1)'(ai1_reg);
            end
            default:
            begin
                sre_next = '0;
                sim_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (kind2_reg == OP_MUL)
        begin
            nre_next = SUM_W'(prr2_reg) - SUM_W'(pii2_reg);
            nim_next = SUM_W'(pri2_reg) + SUM_W'(pir2_reg);
        end
        else
        begin
            nre_next = SUM_W'(prr2_reg) + SUM_W'(pii2_reg);
            nim_next = SUM_W'(pir2_reg) - SUM_W'(pri2_reg);
        end
        ore      = sre2_reg[DATA_W] != sre2_reg[DATA_W-1];
        oim      = sim2_reg[DATA_W] != sim2_reg[DATA_W-1];
        cre_next = ore ? (sre2_reg[DATA_W] ? D_MIN : D_MAX) : data_t'(sre2_reg[DATA_W-1:0]);
        cim_next = oim ? (sim2_reg[DATA_W] ? D_MIN : D_MAX) : data_t'(sim2_reg[DATA_W-1:0]);
    end

    always_comb
    begin
        fre     = $signed(nre3_reg[SUM_W-1:FRAC_W]);
        fim     = $signed(nim3_reg[SUM_W-1:FRAC_W]);
        mre_ovf = (fre > MSH_W'(D_MAX)) || (fre < MSH_W'(D_MIN));
        mim_ovf = (fim > MSH_W'(D_MAX)) || (fim < MSH_W'(D_MIN));
        mre     = mre_ovf ? (fre[MSH_W-1] ? D_MIN : D_MAX) : data_t'(fre[DATA_W-1:0]);
        mim     = mim_ovf ? (fim[MSH_W-1] ? D_MIN : D_MAX) : data_t'(fim[DATA_W-1:0]);

        sb_next.kind   = kind3_reg;
        sb_next.neg_re = nre3_reg[SUM_W-1];
        sb_next.neg_im = nim3_reg[SUM_W-1];
        sb_next.dz     = 1'b0;
        sb_next.re     = '0;
        sb_next.im     = '0;
        sb_next.ovf    = 1'b0;
        unique case (kind3_reg) inside
            OP_MUL:
            begin
                sb_next.re  = mre;
                sb_next.im  = mim;
                sb_next.ovf = mre_ovf || mim_ovf;
            end
            OP_ADD, OP_SUB, OP_CONJ:
            begin
                sb_next.re  = cre3_reg;
                sb_next.im  = cim3_reg;
                sb_next.ovf = covf3_reg;
            end
            OP_DIV:
            begin
                sb_next.dz = den3_reg == '0;
            end
            default:
            begin
                sb_next.dz = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg  <= operands.kind;
            ar1_reg    <= $signed(operands.a_re[DATA_W-1:0]);
            ai1_reg    <= $signed(operands.a_im[DATA_W-1:0]);
            br1_reg    <= $signed(operands.b_re[DATA_W-1:0]);
            bi1_reg    <= $signed(operands.b_im[DATA_W-1:0]);

            kind2_reg  <= kind1_reg;
            prr2_reg   <= PROD_W'(ar1_reg) * PROD_W'(br1_reg);
            pii2_reg   <= PROD_W'(ai1_reg) * PROD_W'(bi1_reg);
            pri2_reg   <= PROD_W'(ar1_reg) * PROD_W'(bi1_reg);
            pir2_reg   <= PROD_W'(ai1_reg) * PROD_W'(br1_reg);
            pbr2_reg   <= PROD_W'(br1_reg) * PROD_W'(br1_reg);
            pbi2_reg   <= PROD_W'(bi1_reg) * PROD_W'(bi1_reg);
            sre2_reg   <= sre_next;
            sim2_reg   <= sim_next;

            kind3_reg  <= kind2_reg;
            nre3_reg   <= nre_next;
            nim3_reg   <= nim_next;
            den3_reg   <= $unsigned(pbr2_reg) + $unsigned(pbi2_reg);
            cre3_reg   <= cre_next;
            cim3_reg   <= cim_next;
            covf3_reg  <= ore || oim;

            sb4_reg    <= sb_next;
            magre4_reg <= PROD_W'(nre3_reg[SUM_W-1] ? -nre3_reg : nre3_reg);
            magim4_reg <= PROD_W'(nim3_reg[SUM_W-1] ? -nim3_reg : nim3_reg);
            den4_reg   <= den3_reg;

            side_reg[0] <= sb4_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            re_reg  <= re_next;
            im_reg  <= im_next;
            dz_reg  <= dz_next;
            ovf_reg <= ovf_next;
        end
    end

    cau_div u_div_re (
        .clk (clk),
        .en  (en),
        .mag (magre4_reg),
        .den (den4_reg),
        .quo (qre),
        .big (bigre)
    );

    cau_div u_div_im (
        .clk (clk),
        .en  (en),
        .mag (magim4_reg),
        .den (den4_reg),
        .quo (qim),
        .big (bigim)
    );

    always_comb
    begin
        sd       = side_reg[DIV_LAT-1];
        sat_re   = bigre || (sd.neg_re ? (qre[DATA_W-1] && (|qre[DATA_W-2:0])) : qre[DATA_W-1]);
        sat_im   = bigim || (sd.neg_im ? (qim[DATA_W-1] && (|qim[DATA_W-2:0])) : qim[DATA_W-1]);
        re_next  = sd.re;
        im_next  = sd.im;
        dz_next  = sd.dz;
        ovf_next = sd.ovf;
        if ((sd.kind == OP_DIV) && !sd.dz)
        begin
            if (sat_re)
            begin
                re_next = sd.neg_re ? D_MIN : D_MAX;
            end
            else
            begin
                re_next = sd.neg_re ? -data_t'(qre) : data_t'(qre);
            end
            if (sat_im)
            begin
                im_next = sd.neg_im ? D_MIN : D_MAX;
            end
            else
            begin
                im_next = sd.neg_im ? -data_t'(qim) : data_t'(qim);
            end
            ovf_next = sat_re || sat_im;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.res_re      = FIELD_W'(re_reg);
    assign result.res_im      = FIELD_W'(im_reg);
    assign result.div_by_zero = dz_reg;
    assign result.overflow    = ovf_reg;

    // A division by zero gives a zero result and never reports saturation.
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dz_reg |-> !ovf_reg && (re_reg == '0) && (im_reg == '0))
        else $error("division by zero result not clean");

    // Saturation leaves at least one part at a limit of the range.
    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ovf_reg |-> (re_reg == D_MAX) || (re_reg == D_MIN) ||
                                     (im_reg == D_MAX) || (im_reg == D_MIN))
        else $error("overflow flagged without a saturated part");

    // The output register holds its transaction while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(re_reg) &&
                                           $stable(im_reg) && $stable(ovf_reg))
        else $error("stalled result changed");

    // Reset empties the output stage.
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid_reg)
        else $error("result valid during reset");

endmodule

`default_nettype wire
